/* src/hsbdc_pkg.sv */
// Shared types, constants and the brightness dim curve for the HSB to RGB converter.
package hsbdc_pkg;

  // Hue circle and sector span in degrees
  localparam int unsigned HUE_CIRCLE  = 360;
  localparam int unsigned SECTOR_SPAN = 60;

  // Reciprocal of 360 for the hue quotient: q = (hue * HUE_RECIP) >> HUE_SHIFT
  localparam logic [15:0] HUE_RECIP = 16'd46604;
  localparam int unsigned HUE_SHIFT = 24;

  // Reciprocal of 60 for the blend quotient: q = (p * DIV60_RECIP) >> DIV60_SHIFT
  localparam logic [15:0] DIV60_RECIP = 16'd34953;
  localparam int unsigned DIV60_SHIFT = 21;

  // Full-scale channel level
  localparam logic [7:0] LEVEL_MAX = 8'd255;

  // 60-degree sector of the hue circle
  typedef enum logic [2:0] {
    SECT_RED_GREEN_UP  = 3'd0,
    SECT_RED_DOWN      = 3'd1,
    SECT_BLUE_UP       = 3'd2,
    SECT_GREEN_DOWN    = 3'd3,
    SECT_RED_UP        = 3'd4,
    SECT_BLUE_DOWN     = 3'd5
  } sector_t;

  // Position of a hue within the circle: sector and offset inside it
  typedef struct packed {
    sector_t    sector;
    logic [5:0] frac;
  } hue_pos_t;

  // Perceptual dim curve
  localparam logic [7:0] DIM_CURVE [256] = '{
    8'd0,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
    8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
    8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd4,
    8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,
    8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,
    8'd5,   8'd5,   8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd6,
    8'd6,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
    8'd7,   8'd7,   8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd8,
    8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,
    8'd10,  8'd10,  8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd11,
    8'd11,  8'd11,  8'd12,  8'd12,  8'd12,  8'd12,  8'd12,  8'd13,
    8'd13,  8'd13,  8'd13,  8'd14,  8'd14,  8'd14,  8'd14,  8'd15,
    8'd15,  8'd15,  8'd16,  8'd16,  8'd16,  8'd16,  8'd17,  8'd17,
    8'd17,  8'd18,  8'd18,  8'd18,  8'd19,  8'd19,  8'd19,  8'd20,
    8'd20,  8'd20,  8'd21,  8'd21,  8'd22,  8'd22,  8'd22,  8'd23,
    8'd23,  8'd24,  8'd24,  8'd25,  8'd25,  8'd25,  8'd26,  8'd26,
    8'd27,  8'd27,  8'd28,  8'd28,  8'd29,  8'd29,  8'd30,  8'd30,
    8'd31,  8'd32,  8'd32,  8'd33,  8'd33,  8'd34,  8'd35,  8'd35,
    8'd36,  8'd36,  8'd37,  8'd38,  8'd38,  8'd39,  8'd40,  8'd40,
    8'd41,  8'd42,  8'd43,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,
    8'd48,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
    8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
    8'd63,  8'd64,  8'd65,  8'd66,  8'd68,  8'd69,  8'd70,  8'd71,
    8'd73,  8'd74,  8'd75,  8'd76,  8'd78,  8'd79,  8'd81,  8'd82,
    8'd83,  8'd85,  8'd86,  8'd88,  8'd90,  8'd91,  8'd93,  8'd94,
    8'd96,  8'd98,  8'd99,  8'd101, 8'd103, 8'd105, 8'd107, 8'd109,
    8'd110, 8'd112, 8'd114, 8'd116, 8'd118, 8'd121, 8'd123, 8'd125,
    8'd127, 8'd129, 8'd132, 8'd134, 8'd136, 8'd139, 8'd141, 8'd144,
    8'd146, 8'd149, 8'd151, 8'd154, 8'd157, 8'd159, 8'd162, 8'd165,
    8'd168, 8'd171, 8'd174, 8'd177, 8'd180, 8'd183, 8'd186, 8'd190,
    8'd193, 8'd196, 8'd200, 8'd203, 8'd207, 8'd211, 8'd214, 8'd218,
    8'd222, 8'd226, 8'd230, 8'd234, 8'd238, 8'd242, 8'd248, 8'd255
  };

endpackage

/* src/hsbdc_hue_split.sv */
// Three-stage hue reduction: modulo 360, then sector and offset within the sector.
module hsbdc_hue_split (
  input  logic                  clk,
  input  logic [15:0]           hue,
  output hsbdc_pkg::hue_pos_t   pos
);

  logic [31:0]          quot_prod;
  logic [7:0]           quot_r;
  logic [15:0]          hue1_r;
  logic [16:0]          circ_mult;
  logic [16:0]          hue_diff;
  logic [8:0]           h_nxt;
  logic [8:0]           h_r;
  hsbdc_pkg::sector_t   sect_nxt;
  logic [8:0]           sect_base;
  logic [8:0]           frac_full;
  hsbdc_pkg::hue_pos_t  pos_r;

  // Stage 1: estimate hue / 360 with a reciprocal multiply
  assign quot_prod = hue * hsbdc_pkg::HUE_RECIP;

  always_ff @(posedge clk) begin
    quot_r <= quot_prod[hsbdc_pkg::HUE_SHIFT +: 8];
    hue1_r <= hue;
  end

  // Stage 2: subtract the whole turns
  assign circ_mult = 17'(quot_r) * 17'(hsbdc_pkg::HUE_CIRCLE);
  assign hue_diff  = {1'b0, hue1_r} - circ_mult;
  assign h_nxt     = hue_diff[8:0];

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
  end

  // Stage 3: pick the sector by compares and keep the offset inside it
  always_comb begin
    if (h_r >= 9'd300) begin
      sect_nxt  = hsbdc_pkg::SECT_BLUE_DOWN;
      sect_base = 9'd300;
    end else if (h_r >= 9'd240) begin
      sect_nxt  = hsbdc_pkg::SECT_RED_UP;
      sect_base = 9'd240;
    end else if (h_r >= 9'd180) begin
      sect_nxt  = hsbdc_pkg::SECT_GREEN_DOWN;
      sect_base = 9'd180;
    end else if (h_r >= 9'd120) begin
      sect_nxt  = hsbdc_pkg::SECT_BLUE_UP;
      sect_base = 9'd120;
    end else if (h_r >= 9'd60) begin
      sect_nxt  = hsbdc_pkg::SECT_RED_DOWN;
      sect_base = 9'd60;
    end else begin
      sect_nxt  = hsbdc_pkg::SECT_RED_GREEN_UP;
      sect_base = 9'd0;
    end
  end

  assign frac_full = h_r - sect_base;

  always_ff @(posedge clk) begin
    pos_r.sector <= sect_nxt;
    pos_r.frac   <= frac_full[5:0];
  end

  assign pos = pos_r;

endmodule

/* src/hsb_to_rgb_dim_curve.sv */
// Top level: pipelined HSB to RGB converter with a perceptual brightness curve.
//
//   port group   direction  role
//   ----------   ---------  -------------------------------------------------
//   start/busy   in/out     request handshake; request taken when start && !busy
//   in_*         in         hue (16 b), saturation (8 b), brightness (8 b)
//   out_*        out        red, green, blue (8 b each), one-cycle out_valid strobe
//
// One request per clock; results come out in request order.
// The five register stages are: curve lookup, base multiply, span subtract
// alongside the sector split, blend multiply and divide-by-60 reciprocal multiply with the channel select.
// busy stays low: the pipeline never stalls and the receiver cannot hold results.
// Reset clears the valid bits only; data registers are not reset.
module hsb_to_rgb_dim_curve (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_hue,
  input  logic [7:0]  in_saturation,
  input  logic [7:0]  in_brightness,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  logic                 req;
  hsbdc_pkg::hue_pos_t  pos;

  logic        vld1_r, vld2_r, vld3_r, vld4_r, out_valid_r;
  logic [7:0]  val1_r, inv_s1_r;
  logic [7:0]  val2_r, base2_r;
  logic        grey2_r;
  logic [15:0] base_prod;
  logic [7:0]  val3_r, base3_r, diff3_r;
  logic        grey3_r;
  logic [5:0]  frac_dn;
  logic [13:0] prod_up4_r, prod_dn4_r;
  logic [7:0]  val4_r, base4_r;
  logic        grey4_r;
  hsbdc_pkg::sector_t sect4_r;
  logic [29:0] quot_up_prod, quot_dn_prod;
  logic [7:0]  up_lvl, dn_lvl;
  logic [7:0]  red_nxt, green_nxt, blue_nxt;
  logic [7:0]  out_red_r, out_green_r, out_blue_r;

  assign busy = 1'b0;
  assign req  = start && !busy;

  // Hue path runs alongside stages 1 to 3
  hsbdc_hue_split u_hue_split (
    .clk (clk),
    .hue (in_hue),
    .pos (pos)
  );

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r      <= 1'b0;
      vld2_r      <= 1'b0;
      vld3_r      <= 1'b0;
      vld4_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld1_r      <= req;
      vld2_r      <= vld1_r;
      vld3_r      <= vld2_r;
      vld4_r      <= vld3_r;
      out_valid_r <= vld4_r;
    end
  end

  // Stage 1: dim curve lookups for brightness and inverted saturation
  always_ff @(posedge clk) begin
    val1_r   <= hsbdc_pkg::DIM_CURVE[in_brightness];
    inv_s1_r <= hsbdc_pkg::DIM_CURVE[hsbdc_pkg::LEVEL_MAX - in_saturation];
  end

  // Stage 2: base level and grey detect
  assign base_prod = inv_s1_r * val1_r;

  always_ff @(posedge clk) begin
    val2_r  <= val1_r;
    base2_r <= base_prod[15:8];
    grey2_r <= (inv_s1_r == hsbdc_pkg::LEVEL_MAX);
  end

  // Stage 3: span between full level and base
  always_ff @(posedge clk) begin
    val3_r  <= val2_r;
    base3_r <= base2_r;
    diff3_r <= val2_r - base2_r;
    grey3_r <= grey2_r;
  end

  // Stage 4: scale the span by the rising and falling fractions
  assign frac_dn = 6'(hsbdc_pkg::SECTOR_SPAN) - pos.frac;

  always_ff @(posedge clk) begin
    prod_up4_r <= diff3_r * pos.frac;
    prod_dn4_r <= diff3_r * frac_dn;
    val4_r     <= val3_r;
    base4_r    <= base3_r;
    grey4_r    <= grey3_r;
    sect4_r    <= pos.sector;
  end

  // Stage 5: divide by 60, add base and route to the channels
  assign quot_up_prod = prod_up4_r * hsbdc_pkg::DIV60_RECIP;
  assign quot_dn_prod = prod_dn4_r * hsbdc_pkg::DIV60_RECIP;
  assign up_lvl = quot_up_prod[hsbdc_pkg::DIV60_SHIFT +: 8] + base4_r;
  assign dn_lvl = quot_dn_prod[hsbdc_pkg::DIV60_SHIFT +: 8] + base4_r;

  always_comb begin
    if (grey4_r) begin
      red_nxt   = val4_r;
      green_nxt = val4_r;
      blue_nxt  = val4_r;
    end else begin
      case (sect4_r)
        hsbdc_pkg::SECT_RED_GREEN_UP: begin
          red_nxt = val4_r;  green_nxt = up_lvl;  blue_nxt = base4_r;
        end
        hsbdc_pkg::SECT_RED_DOWN: begin
          red_nxt = dn_lvl;  green_nxt = val4_r;  blue_nxt = base4_r;
        end
        hsbdc_pkg::SECT_BLUE_UP: begin
          red_nxt = base4_r; green_nxt = val4_r;  blue_nxt = up_lvl;
        end
        hsbdc_pkg::SECT_GREEN_DOWN: begin
          red_nxt = base4_r; green_nxt = dn_lvl;  blue_nxt = val4_r;
        end
        hsbdc_pkg::SECT_RED_UP: begin
          red_nxt = up_lvl;  green_nxt = base4_r; blue_nxt = val4_r;
        end
        default: begin
          red_nxt = val4_r;  green_nxt = base4_r; blue_nxt = dn_lvl;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_red_r   <= red_nxt;
    out_green_r <= green_nxt;
    out_blue_r  <= blue_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  // Every request yields a strobe on out_valid
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    req |-> ##5 out_valid) else $error("request lost in pipeline");

  // No strobe without a matching request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(req, 5)) else $error("result without request");

  // Hue split must land inside one sector
  a_hue_pos: assert property (@(posedge clk) disable iff (!rst_n)
    vld3_r |-> (pos.frac < 6'd60) &&
               (pos.sector != 3'd6) && (pos.sector != 3'd7))
    else $error("hue sector or offset out of range");

  // Base never exceeds the full level
  a_base_le_val: assert property (@(posedge clk) disable iff (!rst_n)
    vld2_r |-> (base2_r <= val2_r)) else $error("base above full level");

endmodule

/* sim/hsb_to_rgb_dim_curve_tb.sv */
// Self-checking testbench for the HSB to RGB converter with brightness dim curve.
module hsb_to_rgb_dim_curve_tb;

  // Run limits
  localparam int unsigned RANDOM_REQUESTS = 750;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned REPORT_LIMIT    = 10;

  // One converted colour
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Directed requests packed as {hue, saturation, brightness}
  localparam int unsigned NUM_DIRECTED = 24;
  localparam logic [31:0] DIRECTED [NUM_DIRECTED] = '{
    {16'd0,     8'd255, 8'd255},
    {16'd65535, 8'd255, 8'd255},
    {16'd65535, 8'd0,   8'd0},
    {16'd0,     8'd0,   8'd0},
    {16'd200,   8'd0,   8'd128},
    {16'd100,   8'd255, 8'd0},
    {16'd359,   8'd255, 8'd255},
    {16'd360,   8'd255, 8'd255},
    {16'd60,    8'd255, 8'd255},
    {16'd119,   8'd200, 8'd200},
    {16'd120,   8'd255, 8'd255},
    {16'd180,   8'd255, 8'd200},
    {16'd240,   8'd255, 8'd255},
    {16'd300,   8'd255, 8'd255},
    {16'd30,    8'd200, 8'd200},
    {16'd90,    8'd200, 8'd200},
    {16'd150,   8'd200, 8'd200},
    {16'd210,   8'd200, 8'd200},
    {16'd270,   8'd200, 8'd200},
    {16'd330,   8'd200, 8'd200},
    {16'd719,   8'd1,   8'd255},
    {16'd43200, 8'd128, 8'd1},
    {16'd32768, 8'd170, 8'd85},
    {16'd21845, 8'd85,  8'd170}
  };

  // Predicts colours for accepted requests and checks them against results
  class rgb_scoreboard;
    rgb_t expected_q[$];
    int   failures;

    function new();
      failures = 0;
    endfunction

    // Record a failure; print only the first few
    function void flag(string what, rgb_t want, rgb_t got);
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("ERROR %s: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d", what,
                 want.red, want.green, want.blue, got.red, got.green, got.blue);
    endfunction

    // Work out the colour of one request
    function rgb_t convert(logic [15:0] hue_raw, logic [7:0] sat, logic [7:0] bri);
      int unsigned hue, v, inv_s, base, f, rise, fall;
      hsbdc_pkg::sector_t sect;
      rgb_t c;
      hue   = hue_raw % hsbdc_pkg::HUE_CIRCLE;
      v     = hsbdc_pkg::DIM_CURVE[bri];
      inv_s = hsbdc_pkg::DIM_CURVE[hsbdc_pkg::LEVEL_MAX - sat];
      if (inv_s == hsbdc_pkg::LEVEL_MAX) begin
        // grey: hue plays no part
        c = {v[7:0], v[7:0], v[7:0]};
      end else begin
        base = (inv_s * v) >> 8;
        f    = hue % hsbdc_pkg::SECTOR_SPAN;
        rise = ((v - base) * f) / hsbdc_pkg::SECTOR_SPAN + base;
        fall = ((v - base) * (hsbdc_pkg::SECTOR_SPAN - f)) / hsbdc_pkg::SECTOR_SPAN + base;
        sect = hsbdc_pkg::sector_t'(hue / hsbdc_pkg::SECTOR_SPAN);
        case (sect)
          hsbdc_pkg::SECT_RED_GREEN_UP: c = {v[7:0],    rise[7:0], base[7:0]};
          hsbdc_pkg::SECT_RED_DOWN:     c = {fall[7:0], v[7:0],    base[7:0]};
          hsbdc_pkg::SECT_BLUE_UP:      c = {base[7:0], v[7:0],    rise[7:0]};
          hsbdc_pkg::SECT_GREEN_DOWN:   c = {base[7:0], fall[7:0], v[7:0]};
          hsbdc_pkg::SECT_RED_UP:       c = {rise[7:0], base[7:0], v[7:0]};
          default:                      c = {v[7:0],    base[7:0], fall[7:0]};
        endcase
      end
      return c;
    endfunction

    function void note_request(logic [15:0] hue_raw, logic [7:0] sat, logic [7:0] bri);
      expected_q.push_back(convert(hue_raw, sat, bri));
    endfunction

    // Compare a result with the oldest expected colour, field by field
    function void check_result(rgb_t got);
      rgb_t want;
      if (expected_q.size() == 0) begin
        flag("result with no request pending", '0, got);
      end else begin
        want = expected_q.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
          flag("colour mismatch", want, got);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Count every colour still owed as a failure
    function void close_out();
      while (expected_q.size() > 0)
        flag("result never arrived", expected_q.pop_front(), 'x);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [15:0] in_hue;
  logic [7:0]  in_saturation;
  logic [7:0]  in_brightness;
  logic        out_valid;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;

  rgb_scoreboard sb;
  int unsigned   stall_cycles;

  hsb_to_rgb_dim_curve uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Present one request from a falling edge and hold it until taken
  task automatic send_request(logic [15:0] hue, logic [7:0] sat, logic [7:0] bri);
    start         <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat;
    in_brightness <= bri;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // Drop start with junk on the data ports for an idle gap of length n
  task automatic idle(int unsigned n);
    repeat (n) begin
      start         <= 1'b0;
      in_hue        <= $urandom;
      in_saturation <= $urandom;
      in_brightness <= $urandom;
      @(negedge clk);
    end
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45)      return 0;
    else if (roll < 80) return $urandom_range(1, 3);
    else if (roll < 95) return $urandom_range(4, 10);
    else                return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_hue();
    case ($urandom_range(0, 3))
      0, 1:    return 16'($urandom_range(0, hsbdc_pkg::HUE_CIRCLE - 1));
      2:       return 16'($urandom);
      default: begin
        // land on or beside a sector boundary, from 0 up to 65519
        case ($urandom_range(0, 2))
          0:       return 16'(hsbdc_pkg::SECTOR_SPAN * $urandom_range(0, 1091));
          1:       return 16'(hsbdc_pkg::SECTOR_SPAN * $urandom_range(0, 1091) + 1);
          default: return 16'(hsbdc_pkg::SECTOR_SPAN * $urandom_range(0, 1091)
                              + hsbdc_pkg::SECTOR_SPAN - 1);
        endcase
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_level(logic allow_one);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10)                   return 8'd0;
    else if (roll < 20)              return 8'd255;
    else if (roll < 25 && allow_one) return 8'd1;
    else                             return 8'($urandom);
  endfunction

  // Take requests and results on the rising edge; watch for a stalled run
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        sb.note_request(in_hue, in_saturation, in_brightness);
      if (out_valid)
        sb.check_result({out_red, out_green, out_blue});
    end
    if ((start && !busy) || out_valid)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("hsb_to_rgb_dim_curve verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned burst_left;
    int unsigned k;
    sb            = new();
    stall_cycles  = 0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_hue        = '0;
    in_saturation = '0;
    in_brightness = '0;
    burst_left    = 0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners, mostly back to back
    for (k = 0; k < NUM_DIRECTED; k++) begin
      send_request(DIRECTED[k][31:16], DIRECTED[k][15:8], DIRECTED[k][7:0]);
      if (k % 5 == 4) idle($urandom_range(1, 4));
    end

    // Random requests with random gaps and occasional gap-free bursts
    for (k = 0; k < RANDOM_REQUESTS; k++) begin
      send_request(pick_hue(), pick_level(1'b1), pick_level(1'b0));
      if (k == 250 || k == 500) begin
        // hold off until the pipeline has emptied
        start <= 1'b0;
        while (sb.pending() > 0) @(negedge clk);
      end else if (burst_left > 0) begin
        burst_left--;
      end else if ($urandom_range(0, 39) == 0) begin
        burst_left = $urandom_range(20, 40);
      end else begin
        idle(pick_gap());
      end
    end

    // Drain, then allow for any stray late result
    idle(1);
    while (sb.pending() > 0) @(negedge clk);
    idle(DRAIN_CYCLES);
    sb.close_out();

    if (sb.failures == 0)
      $display("hsb_to_rgb_dim_curve verification clean");
    else
      $display("hsb_to_rgb_dim_curve verification failed");
    $finish;
  end

endmodule
